>>> hw/rtl/cdt_pkg.sv
// Shared types and codes of the command deduplication table.
`default_nettype none

package cdt_pkg;

    localparam logic [2:0] OP_CHECK      = 3'd0;
    localparam logic [2:0] OP_GET_RESULT = 3'd1;
    localparam logic [2:0] OP_GET_ACCEPT = 3'd2;
    localparam logic [2:0] OP_REC_ACCEPT = 3'd3;
    localparam logic [2:0] OP_REC_FINAL  = 3'd4;
    localparam logic [2:0] OP_POP        = 3'd5;

    localparam logic [1:0] DUP_NONE     = 2'd0;
    localparam logic [1:0] DUP_SAME     = 2'd1;
    localparam logic [1:0] DUP_CONFLICT = 2'd2;

    localparam logic [31:0] WINDOW_RESET = 32'd60000;
    // Register index taken from the word address bit of paddr.
    localparam logic        REG_WINDOW_MS = 1'b0;

    typedef struct packed {
        logic        has_duration;
        logic [15:0] duration_sec;
        logic        has_level;
        logic [7:0]  level_value;
    } t_cdt_params;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic [31:0] request_id;
        logic [15:0] device_id;
        logic [7:0]  command_code;
        logic        has_duration;
        logic [15:0] duration_sec;
        logic        has_level;
        logic [7:0]  level_value;
        logic [63:0] result_word;
    } t_cdt_req;

    typedef struct packed {
        logic        found;
        logic [1:0]  dup_status;
        logic [31:0] out_request_id;
        logic [15:0] out_device_id;
        logic [7:0]  out_command;
        logic        out_has_duration;
        logic [15:0] out_duration_sec;
        logic        out_has_level;
        logic [7:0]  out_level;
        logic [63:0] out_result_word;
        logic        overflow;
    } t_cdt_rsp;

    typedef struct packed {
        logic [31:0] tag;
        logic [15:0] device;
        logic [7:0]  command;
        t_cdt_params params;
        logic        is_final;
        logic [63:0] result;
        logic [31:0] created;
    } t_cdt_entry;

    typedef struct packed {
        logic [31:0] tag;
        logic [15:0] device;
        logic [7:0]  command;
        t_cdt_params params;
    } t_cdt_pend;

endpackage

`default_nettype wire

>>> hw/rtl/cdt_tbl_mem.sv
// Entry store of the deduplication table: one write port, one registered read port.
`default_nettype none

module cdt_tbl_mem
    import cdt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  t_cdt_entry         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output t_cdt_entry               o_rdata
);

    t_cdt_entry r_mem [DEPTH];
    t_cdt_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/cdt_pnd_mem.sv
// Pending request queue store: one write port, one registered read port.
`default_nettype none

module cdt_pnd_mem
    import cdt_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  t_cdt_pend          i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output t_cdt_pend                o_rdata
);

    t_cdt_pend r_mem [DEPTH];
    t_cdt_pend r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/command_dedup_table_top.sv
// Top level of the command deduplication table with its pending request queue.
//
// One request is handled at a time; a response may still wait at the output while the
// next request is taken. A query scans the table entries in order, reading each from the
// registered read port of the entry memory before it is compared. Record and pop first
// compact the table and then check each pending request against the table, then do their
// own work: a further scan of the table for record final, or shifting the queue for pop.
// There is no clearing pass after reset.
`default_nettype none

module command_dedup_table_top
    import cdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int PENDING_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_req_valid,
    output logic        o_req_stall,
    input  wire t_cdt_req i_req,
    output logic        o_rsp_valid,
    input  wire         i_rsp_stall,
    output t_cdt_rsp    o_rsp,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TW  = $clog2(TABLE_ENTRIES);
    localparam int CW  = TW + 1;
    localparam int PW  = $clog2(PENDING_DEPTH);
    localparam int PCW = PW + 1;

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_Q_RD = 16'h0002,
        S_Q_EV = 16'h0004,
        S_P_RD = 16'h0008,
        S_P_EV = 16'h0010,
        S_R_RD = 16'h0020,
        S_R_EV = 16'h0040,
        S_R_SC = 16'h0080,
        S_R_CK = 16'h0100,
        S_ACT  = 16'h0200,
        S_F_RD = 16'h0400,
        S_F_EV = 16'h0800,
        S_O_EV = 16'h1000,
        S_O_RD = 16'h2000,
        S_O_WR = 16'h4000,
        S_FIN  = 16'h8000
    } t_state;

    t_state           r_state;
    t_cdt_req         r_req;
    t_cdt_rsp         r_res;
    t_cdt_rsp         r_out;
    logic             r_ovalid;
    logic [31:0]      r_window;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_j;
    logic [PCW-1:0]   r_pcnt;
    logic [PCW-1:0]   r_pi;
    logic [PCW-1:0]   r_pk;
    t_cdt_pend        r_pe;

    logic             t_we;
    logic [TW-1:0]    t_waddr;
    logic [TW-1:0]    t_raddr;
    t_cdt_entry       t_wdata;
    t_cdt_entry       t_rdata;
    logic             p_we;
    logic [PW-1:0]    p_waddr;
    logic [PW-1:0]    p_raddr;
    t_cdt_pend        p_wdata;
    t_cdt_pend        p_rdata;

    t_cdt_params      w_params;
    logic [31:0]      w_age;
    logic             w_keep;
    logic             w_tbl_room;
    logic             w_pnd_room;
    logic             w_accept;
    logic             w_cfg_wr;
    logic [PCW-1:0]   w_prev;
    logic             w_rsp_load;

    assign w_params   = '{has_duration: r_req.has_duration, duration_sec: r_req.duration_sec,
                          has_level: r_req.has_level, level_value: r_req.level_value};
    assign w_age      = r_req.now_ms - t_rdata.created;
    assign w_keep     = (w_age <= r_window);
    assign w_tbl_room = (r_cnt < CW'(TABLE_ENTRIES));
    assign w_pnd_room = (r_pcnt < PCW'(PENDING_DEPTH));
    assign w_prev     = r_pi - PCW'(1);
    assign w_rsp_load = (r_state == S_FIN) && (!r_ovalid || !i_rsp_stall);

    assign o_req_stall = (r_state != S_IDLE);
    assign w_accept    = i_req_valid && (r_state == S_IDLE);
    assign o_rsp_valid = r_ovalid;
    assign o_rsp       = r_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_MS);
    assign prdata   = (paddr[2] == REG_WINDOW_MS) ? r_window : 32'd0;

    // Memory port control follows the state of the sequencer.
    always_comb begin
        t_we    = 1'b0;
        t_waddr = r_n[TW-1:0];
        t_wdata = t_rdata;
        t_raddr = r_i[TW-1:0];
        p_we    = 1'b0;
        p_waddr = r_pk[PW-1:0];
        p_wdata = r_pe;
        p_raddr = r_pi[PW-1:0];
        case (r_state)
            S_P_EV: begin
                t_we = w_keep;
            end
            S_R_SC: begin
                t_raddr = r_j[TW-1:0];
            end
            S_R_CK: begin
                p_we = (t_rdata.tag == r_pe.tag) && !t_rdata.is_final;
            end
            S_ACT: begin
                p_raddr = '0;
                if (r_req.operation == OP_REC_ACCEPT) begin
                    t_we    = w_tbl_room;
                    t_waddr = r_cnt[TW-1:0];
                    t_wdata = '{tag: r_req.request_id, device: r_req.device_id,
                                command: r_req.command_code, params: w_params,
                                is_final: 1'b0, result: 64'd0, created: r_req.now_ms};
                    p_we    = w_pnd_room;
                    p_waddr = r_pcnt[PW-1:0];
                    p_wdata = '{tag: r_req.request_id, device: r_req.device_id,
                                command: r_req.command_code, params: w_params};
                end
            end
            S_F_RD: begin
                t_waddr = r_cnt[TW-1:0];
                t_wdata = '{tag: r_req.request_id, device: r_req.device_id,
                            command: 8'd0, params: '0, is_final: 1'b1,
                            result: r_req.result_word, created: r_req.now_ms};
                t_we    = (r_i == r_cnt) && w_tbl_room;
            end
            S_F_EV: begin
                t_waddr          = r_i[TW-1:0];
                t_wdata          = t_rdata;
                t_wdata.is_final = 1'b1;
                t_wdata.result   = r_req.result_word;
                t_we             = (t_rdata.tag == r_req.request_id);
            end
            S_O_WR: begin
                p_we    = 1'b1;
                p_waddr = w_prev[PW-1:0];
                p_wdata = p_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_window <= WINDOW_RESET;
            r_cnt    <= '0;
            r_pcnt   <= '0;
        end else begin
            if (w_cfg_wr) begin
                r_window <= pwdata;
            end
            if (w_rsp_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_rsp_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req <= i_req;
                        r_res <= '0;
                        r_i   <= '0;
                        r_n   <= '0;
                        case (i_req.operation)
                            OP_CHECK, OP_GET_RESULT, OP_GET_ACCEPT: r_state <= S_Q_RD;
                            OP_REC_ACCEPT, OP_REC_FINAL, OP_POP:    r_state <= S_P_RD;
                            default:                                r_state <= S_FIN;
                        endcase
                    end
                end
                S_Q_RD: begin
                    r_state <= (r_i == r_cnt) ? S_FIN : S_Q_EV;
                end
                S_Q_EV: begin
                    if ((t_rdata.tag == r_req.request_id) &&
                        ((r_req.operation != OP_GET_RESULT) || t_rdata.is_final)) begin
                        r_res.found <= 1'b1;
                        case (r_req.operation)
                            OP_CHECK: begin
                                r_res.dup_status <= ((t_rdata.device == r_req.device_id) &&
                                                     (t_rdata.command == r_req.command_code) &&
                                                     (t_rdata.params == w_params))
                                                    ? DUP_SAME : DUP_CONFLICT;
                            end
                            OP_GET_RESULT: begin
                                r_res.out_result_word <= t_rdata.result;
                            end
                            default: begin
                                r_res.out_request_id   <= t_rdata.tag;
                                r_res.out_device_id    <= t_rdata.device;
                                r_res.out_command      <= t_rdata.command;
                                r_res.out_has_duration <= t_rdata.params.has_duration;
                                r_res.out_duration_sec <= t_rdata.params.duration_sec;
                                r_res.out_has_level    <= t_rdata.params.has_level;
                                r_res.out_level        <= t_rdata.params.level_value;
                            end
                        endcase
                        r_state <= S_FIN;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_Q_RD;
                    end
                end
                S_P_RD: begin
                    if (r_i == r_cnt) begin
                        r_cnt   <= r_n;
                        r_pi    <= '0;
                        r_pk    <= '0;
                        r_state <= S_R_RD;
                    end else begin
                        r_state <= S_P_EV;
                    end
                end
                S_P_EV: begin
                    if (w_keep) begin
                        r_n <= r_n + CW'(1);
                    end
                    r_i     <= r_i + CW'(1);
                    r_state <= S_P_RD;
                end
                S_R_RD: begin
                    if (r_pi == r_pcnt) begin
                        r_pcnt  <= r_pk;
                        r_i     <= '0;
                        r_state <= S_ACT;
                    end else begin
                        r_state <= S_R_EV;
                    end
                end
                S_R_EV: begin
                    r_pe    <= p_rdata;
                    r_j     <= '0;
                    r_state <= S_R_SC;
                end
                S_R_SC: begin
                    if (r_j == r_cnt) begin
                        r_pi    <= r_pi + PCW'(1);
                        r_state <= S_R_RD;
                    end else begin
                        r_state <= S_R_CK;
                    end
                end
                S_R_CK: begin
                    if ((t_rdata.tag == r_pe.tag) && !t_rdata.is_final) begin
                        r_pk    <= r_pk + PCW'(1);
                        r_pi    <= r_pi + PCW'(1);
                        r_state <= S_R_RD;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_R_SC;
                    end
                end
                S_ACT: begin
                    case (r_req.operation)
                        OP_REC_ACCEPT: begin
                            if (w_tbl_room) begin
                                r_cnt <= r_cnt + CW'(1);
                            end
                            if (w_pnd_room) begin
                                r_pcnt <= r_pcnt + PCW'(1);
                            end
                            r_res.overflow <= !w_tbl_room || !w_pnd_room;
                            r_state        <= S_FIN;
                        end
                        OP_REC_FINAL: begin
                            r_state <= S_F_RD;
                        end
                        OP_POP: begin
                            r_state <= (r_pcnt == '0) ? S_FIN : S_O_EV;
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_F_RD: begin
                    if (r_i == r_cnt) begin
                        if (w_tbl_room) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_res.overflow <= 1'b1;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_F_EV;
                    end
                end
                S_F_EV: begin
                    if (t_rdata.tag == r_req.request_id) begin
                        r_state <= S_FIN;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_F_RD;
                    end
                end
                S_O_EV: begin
                    r_res.found            <= 1'b1;
                    r_res.out_request_id   <= p_rdata.tag;
                    r_res.out_device_id    <= p_rdata.device;
                    r_res.out_command      <= p_rdata.command;
                    r_res.out_has_duration <= p_rdata.params.has_duration;
                    r_res.out_duration_sec <= p_rdata.params.duration_sec;
                    r_res.out_has_level    <= p_rdata.params.has_level;
                    r_res.out_level        <= p_rdata.params.level_value;
                    r_pi                   <= PCW'(1);
                    r_state                <= S_O_RD;
                end
                S_O_RD: begin
                    if (r_pi == r_pcnt) begin
                        r_pcnt  <= r_pcnt - PCW'(1);
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_O_WR;
                    end
                end
                S_O_WR: begin
                    r_pi    <= r_pi + PCW'(1);
                    r_state <= S_O_RD;
                end
                S_FIN: begin
                    if (w_rsp_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    cdt_tbl_mem #(
        .DEPTH(TABLE_ENTRIES)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    cdt_pnd_mem #(
        .DEPTH(PENDING_DEPTH)
    ) u_pnd (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

endmodule

`default_nettype wire

>>> test/command_dedup_table_top_test.sv
// Self-checking testbench for the command deduplication table top level.
`timescale 1ns / 100ps
`default_nettype none

module command_dedup_table_top_test;
    import cdt_pkg::*;

    localparam int NUM_ENTRIES = 16;
    localparam int NUM_PENDING = 16;
    localparam int RANDOM_ITEMS = 660;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 4000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    t_cdt_req    req;
    logic        rsp_valid;
    logic        rsp_stall;
    t_cdt_rsp    rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    command_dedup_table_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_req_valid(req_valid), .o_req_stall(req_stall), .i_req(req),
        .o_rsp_valid(rsp_valid), .i_rsp_stall(rsp_stall), .o_rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Predictor state: table in insertion order and the pending queue.
    t_cdt_entry  tbl_q[$];
    t_cdt_pend   pend_q[$];
    logic [31:0] window;

    t_cdt_rsp    expected_q[$];
    int          errors;
    int          cycles;
    int          accepted;
    int          checked;
    logic        quiet;
    bit          rsp_idle_on;
    bit          req_idle_on;
    int          ops_seen[6];

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("command_dedup_table_top_test failed");
            $finish;
        end
    end

    function automatic t_cdt_params params_of(t_cdt_req r);
        t_cdt_params p;
        p.has_duration = r.has_duration;
        p.duration_sec = r.duration_sec;
        p.has_level = r.has_level;
        p.level_value = r.level_value;
        return p;
    endfunction

    function automatic int find_entry(logic [31:0] tag, bit need_final);
        foreach (tbl_q[i])
            if (tbl_q[i].tag == tag && (!need_final || tbl_q[i].is_final))
                return i;
        return -1;
    endfunction

    // Drop aged entries, then pending requests without an accepted entry.
    function automatic void expire_entries(logic [31:0] now);
        t_cdt_entry kept[$];
        t_cdt_pend  live[$];
        bit         keep;
        logic [31:0] age;
        foreach (tbl_q[i]) begin
            age = now - tbl_q[i].created;
            if (age <= window)
                kept.insert(kept.size(), tbl_q[i]);
        end
        tbl_q = kept;
        foreach (pend_q[i]) begin
            keep = 0;
            foreach (tbl_q[j])
                if (tbl_q[j].tag == pend_q[i].tag && !tbl_q[j].is_final)
                    keep = 1;
            if (keep)
                live.insert(live.size(), pend_q[i]);
        end
        pend_q = live;
    endfunction

    function automatic t_cdt_rsp request_fields(logic [31:0] tag, logic [15:0] dev,
                                                logic [7:0] cmd, t_cdt_params p);
        t_cdt_rsp o;
        o = '0;
        o.found = 1'b1;
        o.out_request_id = tag;
        o.out_device_id = dev;
        o.out_command = cmd;
        o.out_has_duration = p.has_duration;
        o.out_duration_sec = p.duration_sec;
        o.out_has_level = p.has_level;
        o.out_level = p.level_value;
        return o;
    endfunction

    function automatic t_cdt_rsp dedup_step(t_cdt_req r);
        t_cdt_rsp    o;
        t_cdt_entry  e;
        t_cdt_pend   pr;
        t_cdt_params p;
        int          idx;
        o = '0;
        p = params_of(r);
        case (r.operation)
            OP_CHECK: begin
                idx = find_entry(r.request_id, 0);
                if (idx >= 0) begin
                    o.found = 1'b1;
                    o.dup_status = (tbl_q[idx].device == r.device_id &&
                                    tbl_q[idx].command == r.command_code &&
                                    tbl_q[idx].params == p) ? DUP_SAME : DUP_CONFLICT;
                end
            end
            OP_GET_RESULT: begin
                idx = find_entry(r.request_id, 1);
                if (idx >= 0) begin
                    o.found = 1'b1;
                    o.out_result_word = tbl_q[idx].result;
                end
            end
            OP_GET_ACCEPT: begin
                idx = find_entry(r.request_id, 0);
                if (idx >= 0)
                    o = request_fields(tbl_q[idx].tag, tbl_q[idx].device,
                                       tbl_q[idx].command, tbl_q[idx].params);
            end
            OP_REC_ACCEPT: begin
                expire_entries(r.now_ms);
                if (tbl_q.size() < NUM_ENTRIES) begin
                    e = '{tag: r.request_id, device: r.device_id, command: r.command_code,
                          params: p, is_final: 1'b0, result: 64'd0, created: r.now_ms};
                    tbl_q.insert(tbl_q.size(), e);
                end else begin
                    o.overflow = 1'b1;
                end
                if (pend_q.size() < NUM_PENDING) begin
                    pr = '{tag: r.request_id, device: r.device_id, command: r.command_code,
                           params: p};
                    pend_q.insert(pend_q.size(), pr);
                end else begin
                    o.overflow = 1'b1;
                end
            end
            OP_REC_FINAL: begin
                expire_entries(r.now_ms);
                idx = find_entry(r.request_id, 0);
                if (idx >= 0) begin
                    tbl_q[idx].is_final = 1'b1;
                    tbl_q[idx].result = r.result_word;
                end else if (tbl_q.size() < NUM_ENTRIES) begin
                    e = '{tag: r.request_id, device: r.device_id, command: 8'd0,
                          params: '0, is_final: 1'b1, result: r.result_word,
                          created: r.now_ms};
                    tbl_q.insert(tbl_q.size(), e);
                end else begin
                    o.overflow = 1'b1;
                end
            end
            OP_POP: begin
                expire_entries(r.now_ms);
                if (pend_q.size() > 0) begin
                    pr = pend_q.pop_front();
                    o = request_fields(pr.tag, pr.device, pr.command, pr.params);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // Response checker and random output stall.
    int rsp_burst;
    always @(posedge clk) begin
        t_cdt_rsp want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: response with none expected: %h", $realtime, rsp);
                errors++;
            end else begin
                want = expected_q.pop_front();
                checked++;
                if (rsp !== want) begin
                    $display("%0t: response mismatch expected %h actual %h",
                             $realtime, want, rsp);
                    if (rsp.found !== want.found ||
                        rsp.dup_status !== want.dup_status ||
                        rsp.overflow !== want.overflow)
                        $display("  found/dup/overflow expected %b/%0d/%b actual %b/%0d/%b",
                                 want.found, want.dup_status, want.overflow,
                                 rsp.found, rsp.dup_status, rsp.overflow);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk) begin
        if (!rsp_idle_on || quiet) begin
            rsp_stall <= 1'b0;
            rsp_burst <= 0;
        end else if (rsp_burst > 0) begin
            rsp_burst <= rsp_burst - 1;
            rsp_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            rsp_burst <= $urandom_range(0, 18);
            rsp_stall <= 1'b1;
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    // Present one request, predict it when it is taken. The valid stays high
    // after the last request is taken; the next gap or the caller drops it.
    task automatic send_request(t_cdt_req r, bit typed, t_cdt_rsp typed_rsp);
        t_cdt_rsp pred;
        int gap;
        if (req_idle_on && !quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        pred = dedup_step(r);
        if (typed && pred !== typed_rsp) begin
            $display("%0t: predictor disagrees with table row, expected %h got %h",
                     $realtime, typed_rsp, pred);
            errors++;
        end
        expected_q.insert(expected_q.size(), pred);
        if (r.operation <= OP_POP)
            ops_seen[r.operation]++;
        accepted++;
        @(negedge clk);
    endtask

    task automatic write_window(logic [31:0] value);
        req_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {REG_WINDOW_MS, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== value || pready !== 1'b1) begin
            $display("%0t: window read back expected %h actual %h (ready %b)",
                     $realtime, value, prdata, pready);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        window = value;
    endtask

    function automatic t_cdt_req make_req(logic [2:0] op, logic [31:0] now,
                                          logic [31:0] tag, logic [15:0] dev,
                                          logic [7:0] cmd, logic [25:0] prm,
                                          logic [63:0] res);
        t_cdt_req r;
        r.operation = op;
        r.now_ms = now;
        r.request_id = tag;
        r.device_id = dev;
        r.command_code = cmd;
        {r.has_duration, r.duration_sec, r.has_level, r.level_value} = prm;
        r.result_word = res;
        return r;
    endfunction

    typedef struct {
        t_cdt_req req;
        bit       typed;
        t_cdt_rsp rsp;
    } t_stim_row;

    t_stim_row directed_rows[$];

    task automatic add_row(t_cdt_req r, bit typed, t_cdt_rsp o);
        t_stim_row row;
        row.req = r;
        row.typed = typed;
        row.rsp = o;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic t_cdt_req random_req(int phase, int tag_span);
        logic [2:0]  op;
        logic [31:0] tag;
        logic [31:0] now;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) op = OP_REC_ACCEPT;
        else if (pick < 40) op = OP_REC_FINAL;
        else if (pick < 55) op = OP_POP;
        else if (pick < 72) op = OP_CHECK;
        else if (pick < 84) op = OP_GET_RESULT;
        else if (pick < 97) op = OP_GET_ACCEPT;
        else op = 3'($urandom_range(6, 7));
        // Small tag pool so that lookups hit; now and then a wide random tag.
        tag = ($urandom_range(0, 9) == 0) ? 32'($urandom()) :
              32'h5a00_0000 | 32'($urandom_range(0, tag_span));
        now = 32'(phase * 1000 + $urandom_range(0, 40));
        if ($urandom_range(0, 15) == 0)
            now = 32'($urandom());
        return make_req(op, now, tag,
                        ($urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom())),
                        ($urandom_range(0, 1) ? 8'($urandom_range(0, 2)) : 8'($urandom())),
                        ($urandom_range(0, 1) ? 26'd0 : 26'($urandom())),
                        {32'($urandom()), 32'($urandom())});
    endfunction

    initial begin
        t_cdt_rsp o;
        t_cdt_req r;
        int phase;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        accepted = 0;
        checked = 0;
        quiet = 1'b0;
        rsp_idle_on = 1'b1;
        req_idle_on = 1'b1;
        rsp_burst = 0;
        window = WINDOW_RESET;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table first, then extremes, duplicates and overflow.
        o = '0;
        add_row(make_req(OP_CHECK, 32'd0, 32'hffff_ffff, 16'hffff, 8'hff, '1, '1), 1, o);
        add_row(make_req(OP_GET_RESULT, 32'd0, 32'd0, 16'd0, 8'd0, '0, '0), 1, o);
        add_row(make_req(OP_GET_ACCEPT, 32'd0, 32'd0, 16'd0, 8'd0, '0, '0), 1, o);
        add_row(make_req(OP_POP, 32'hffff_ffff, 32'd0, 16'd0, 8'd0, '0, '0), 1, o);
        add_row(make_req(3'd6, 32'd0, 32'd1, 16'd1, 8'd1, '1, '1), 1, o);
        add_row(make_req(3'd7, 32'd0, 32'd1, 16'd1, 8'd1, '1, '1), 1, o);
        add_row(make_req(OP_REC_ACCEPT, 32'd100, 32'hffff_ffff, 16'hffff, 8'hff, '1, '0), 1, o);
        add_row(make_req(OP_REC_ACCEPT, 32'd100, 32'd0, 16'd0, 8'd0, '0, '0), 1, o);
        o.found = 1'b1;
        o.dup_status = DUP_SAME;
        add_row(make_req(OP_CHECK, 32'd0, 32'hffff_ffff, 16'hffff, 8'hff, '1, '0), 1, o);
        o.dup_status = DUP_CONFLICT;
        add_row(make_req(OP_CHECK, 32'd0, 32'hffff_ffff, 16'hffff, 8'hff, 26'h1ff_fffe, '0),
                1, o);
        add_row(make_req(OP_CHECK, 32'd0, 32'd0, 16'd1, 8'd0, '0, '0), 1, o);
        add_row(make_req(OP_GET_ACCEPT, 32'd0, 32'hffff_ffff, 16'd0, 8'd0, '0, '0), 0, o);
        add_row(make_req(OP_REC_FINAL, 32'd200, 32'hffff_ffff, 16'd0, 8'd0, '0, '1), 0, o);
        add_row(make_req(OP_GET_RESULT, 32'd0, 32'hffff_ffff, 16'd0, 8'd0, '0, '0), 0, o);
        add_row(make_req(OP_REC_FINAL, 32'd200, 32'h1234, 16'h7, 8'd0, '0, 64'h8000_0001),
                0, o);
        // Pops: the finished request is dropped, the other returned.
        add_row(make_req(OP_POP, 32'd300, 32'd0, 16'd0, 8'd0, '0, '0), 0, o);
        add_row(make_req(OP_POP, 32'd300, 32'd0, 16'd0, 8'd0, '0, '0), 0, o);
        // Fill the table to force overflow of the entry store.
        for (int i = 0; i < 17; i++)
            add_row(make_req(OP_REC_ACCEPT, 32'd400, 32'($urandom()), 16'($urandom()),
                             8'($urandom()), 26'($urandom()), '0), 0, o);
        // Expiry: an age of one past the window expires everything.
        add_row(make_req(OP_POP, 32'd400 + WINDOW_RESET + 1, 32'd0, 16'd0, 8'd0, '0, '0),
                0, o);
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

        // Zero window: only entries made at the same millisecond survive.
        write_window(32'd0);
        for (int i = 0; i < 20; i++)
            send_request(random_req(i / 4, 5), 0, o);
        write_window(32'hffff_ffff);
        for (int i = 0; i < 40; i++)
            send_request(random_req(i, 7), 0, o);

        // Main random part, window changed between phases.
        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: write_window(WINDOW_RESET);
                1: write_window(32'd1500);
                2: write_window(32'($urandom_range(0, 5000)));
                3: write_window(32'd500);
                4: write_window(32'($urandom()));
                default: write_window(32'd3000);
            endcase
            if (seg == 5) begin
                quiet = 1'b1;
            end
            phase = $urandom_range(0, 1000);
            for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
                if (i % 8 == 0)
                    phase++;
                send_request(random_req(phase, 10 + seg * 2), 0, o);
            end
        end

        req_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d requests (%0d checked): check %0d, get result %0d, get accepted %0d,",
                 accepted, checked, ops_seen[0], ops_seen[1], ops_seen[2]);
        $display("record accepted %0d, record final %0d, pop %0d, over several windows.",
                 ops_seen[3], ops_seen[4], ops_seen[5]);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("command_dedup_table_top_test passed");
        end else begin
            $display("command_dedup_table_top_test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
